### sv/lhpe_pkg.sv
// ============================================================================
// lhpe_pkg
// Shared types and constants of the log2 histogram percentile engine.
// ============================================================================
`default_nettype none

package lhpe_pkg;

   // Field widths that the interface fixes.
   localparam int COUNT_W   = 64;
   localparam int PCT_W     = 7;
   localparam int NUM_PCT   = 3;
   localparam int CSR_IDX_W = 2;
   localparam int PROD_W    = COUNT_W + PCT_W;
   localparam int PCT_SCALE = 100;

   // Request commands.
   localparam logic CMD_ADD    = 1'b0;
   localparam logic CMD_REPORT = 1'b1;

   // Configuration register indexes.
   localparam logic [CSR_IDX_W-1:0] CSR_PCT_FIRST  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_PCT_SECOND = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_PCT_THIRD  = 2'd2;

   // Percent levels after reset.
   localparam logic [PCT_W-1:0] PCT_FIRST_RESET  = 7'd50;
   localparam logic [PCT_W-1:0] PCT_SECOND_RESET = 7'd95;
   localparam logic [PCT_W-1:0] PCT_THIRD_RESET  = 7'd99;

   typedef struct packed {
      logic        command;
      logic        direction;
      logic [4:0]  slot;
      logic [31:0] slot_add;
      logic [63:0] count_add;
      logic [63:0] bytes_add;
   } req_type;

   typedef struct packed {
      logic        out_direction;
      logic [63:0] op_count;
      logic [63:0] op_bytes;
      logic [31:0] value_first;
      logic [31:0] value_second;
      logic [31:0] value_third;
      logic [32:0] max_value;
      logic        last;
   } rsp_type;

   // Controller to datapath commands.
   typedef struct packed {
      logic add_capture;
      logic add_write;
      logic load;
      logic load_dir;
      logic scan_step;
      logic rsp_load;
      logic clear_all;
   } dp_cmd_type;

   // Datapath to controller status.
   typedef struct packed {
      logic totals_zero;
      logic scan_last;
      logic pipe_busy;
      logic rsp_free;
   } dp_sts_type;

endpackage

`default_nettype wire

### sv/lhpe_datapath.sv
// ============================================================================
// lhpe_datapath
// Bucket memory, totals, percent registers, scan pipeline and result register.
// ============================================================================
`default_nettype none

module lhpe_datapath #(
   parameter int BUCKETS = 32
) (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire lhpe_pkg::req_type                  req_data,
   output logic                                    rsp_valid,
   input  wire logic                               rsp_stall,
   output lhpe_pkg::rsp_type                       rsp_data,
   input  wire logic                               csr_write_en,
   input  wire logic [lhpe_pkg::CSR_IDX_W-1:0]     csr_index,
   input  wire logic [lhpe_pkg::PCT_W-1:0]         csr_wdata,
   input  wire lhpe_pkg::dp_cmd_type               cmd,
   output lhpe_pkg::dp_sts_type                    sts
);

   localparam int SW    = $clog2(BUCKETS);
   localparam int SW1   = SW + 1;
   localparam int AW    = SW + 1;
   localparam int DEPTH = 2 ** AW;
   // Running sum times 100, plus 100: at most 100 * BUCKETS * 2^32.
   localparam int ACC_W = 32 + SW + 7;
   localparam int PW    = lhpe_pkg::PROD_W;
   localparam int NP    = lhpe_pkg::NUM_PCT;

   // Configuration and totals.
   logic [lhpe_pkg::PCT_W-1:0]   pct_ff [NP];
   logic [lhpe_pkg::COUNT_W-1:0] op_ff [2];
   logic [lhpe_pkg::COUNT_W-1:0] byte_ff [2];

   // Bucket memory with one valid bit per entry; an invalid entry reads as zero.
   logic [31:0]      mem [DEPTH];
   logic [DEPTH-1:0] vld_ff;
   logic [AW-1:0]    rd_addr;
   logic [31:0]      rd_data_ff;
   logic             rd_hit_ff;
   logic [31:0]      rd_word;

   // Pending bucket add.
   logic [AW-1:0] add_addr_ff;
   logic [31:0]   add_amt_ff;
   logic          add_en_ff;
   logic [31:0]   add_sum;

   // Per-direction report context.
   logic          cur_dir_ff;
   logic          count_zero_ff;
   logic [PW-1:0] prod_ff [NP];
   logic [SW-1:0] idx_ff;
   logic [lhpe_pkg::COUNT_W-1:0] load_cnt;

   // Scan pipeline.
   logic             p1_vld_ff, p2_vld_ff, p3_vld_ff;
   logic [SW-1:0]    p1_idx_ff, p2_idx_ff, p3_idx_ff;
   logic [ACC_W-1:0] scaled_ff;
   logic [ACC_W-1:0] acc_ff;
   logic [NP-1:0]    found_ff;
   logic [SW-1:0]    hit_idx_ff [NP];
   logic             max_seen_ff;
   logic [SW-1:0]    max_idx_ff;

   // Result register.
   logic              rsp_valid_ff;
   lhpe_pkg::rsp_type rsp_ff;
   logic [SW:0]       max_shift;

   function automatic logic [31:0] midpoint(input logic hit, input logic [SW-1:0] idx);
      logic [31:0] val;
      if (!hit) begin
         val = 32'(1) << (BUCKETS - 1);
      end else if (idx == '0) begin
         val = 32'd1;
      end else begin
         val = 32'(3) << (idx - SW'(1));
      end
      return val;
   endfunction

   assign rd_addr  = cmd.add_capture ? {req_data.direction, req_data.slot[SW-1:0]}
                                     : {cur_dir_ff, idx_ff};
   assign rd_word  = rd_hit_ff ? rd_data_ff : 32'd0;
   assign add_sum  = rd_word + add_amt_ff;
   assign load_cnt = op_ff[cmd.load_dir];
   assign max_shift = {1'b0, max_idx_ff} + SW1'(1);

   // Memory port: one registered read and one write per cycle.
   always_ff @(posedge clock) begin
      if (cmd.add_write && add_en_ff) begin
         mem[add_addr_ff] <= add_sum;
      end
      rd_data_ff <= mem[rd_addr];
      rd_hit_ff  <= vld_ff[rd_addr];
   end

   // Control state, totals and configuration.
   always_ff @(posedge clock) begin
      if (reset) begin
         pct_ff[0]    <= lhpe_pkg::PCT_FIRST_RESET;
         pct_ff[1]    <= lhpe_pkg::PCT_SECOND_RESET;
         pct_ff[2]    <= lhpe_pkg::PCT_THIRD_RESET;
         op_ff[0]     <= '0;
         op_ff[1]     <= '0;
         byte_ff[0]   <= '0;
         byte_ff[1]   <= '0;
         vld_ff       <= '0;
         p1_vld_ff    <= 1'b0;
         p2_vld_ff    <= 1'b0;
         p3_vld_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_write_en) begin
            unique case (csr_index)
               lhpe_pkg::CSR_PCT_FIRST:  pct_ff[0] <= csr_wdata;
               lhpe_pkg::CSR_PCT_SECOND: pct_ff[1] <= csr_wdata;
               lhpe_pkg::CSR_PCT_THIRD:  pct_ff[2] <= csr_wdata;
               default: ;
            endcase
         end

         if (cmd.clear_all) begin
            op_ff[0]   <= '0;
            op_ff[1]   <= '0;
            byte_ff[0] <= '0;
            byte_ff[1] <= '0;
            vld_ff     <= '0;
         end else if (cmd.add_capture) begin
            op_ff[req_data.direction]   <= op_ff[req_data.direction] + req_data.count_add;
            byte_ff[req_data.direction] <= byte_ff[req_data.direction] + req_data.bytes_add;
         end else if (cmd.add_write && add_en_ff) begin
            vld_ff[add_addr_ff] <= 1'b1;
         end

         p1_vld_ff <= cmd.scan_step;
         p2_vld_ff <= p1_vld_ff;
         p3_vld_ff <= p2_vld_ff;

         if (cmd.rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      if (cmd.add_capture) begin
         add_addr_ff <= {req_data.direction, req_data.slot[SW-1:0]};
         add_amt_ff  <= req_data.slot_add;
         add_en_ff   <= {1'b0, req_data.slot} < 6'(BUCKETS);
      end

      if (cmd.load) begin
         cur_dir_ff    <= cmd.load_dir;
         count_zero_ff <= (load_cnt == '0);
         for (int k = 0; k < NP; k++) begin
            prod_ff[k] <= PW'(load_cnt) * PW'(pct_ff[k]);
         end
         idx_ff      <= '0;
         acc_ff      <= ACC_W'(lhpe_pkg::PCT_SCALE);
         found_ff    <= '0;
         max_seen_ff <= 1'b0;
      end else begin
         if (cmd.scan_step) begin
            idx_ff <= idx_ff + SW'(1);
         end
         if (p2_vld_ff) begin
            acc_ff <= acc_ff + scaled_ff;
         end
         if (p3_vld_ff) begin
            // 100 * (sum + 1) > count * p is the same as sum >= floor(count * p / 100).
            for (int k = 0; k < NP; k++) begin
               if (!found_ff[k] && (PW'(acc_ff) > prod_ff[k])) begin
                  found_ff[k]   <= 1'b1;
                  hit_idx_ff[k] <= p3_idx_ff;
               end
            end
         end
         if (p1_vld_ff && (rd_word != 32'd0)) begin
            max_seen_ff <= 1'b1;
            max_idx_ff  <= p1_idx_ff;
         end
      end

      p1_idx_ff <= idx_ff;
      p2_idx_ff <= p1_idx_ff;
      p3_idx_ff <= p2_idx_ff;
      scaled_ff <= (ACC_W'(rd_word) << 6) + (ACC_W'(rd_word) << 5) + (ACC_W'(rd_word) << 2);

      if (cmd.rsp_load) begin
         rsp_ff.out_direction <= cur_dir_ff;
         rsp_ff.op_count      <= op_ff[cur_dir_ff];
         rsp_ff.op_bytes      <= byte_ff[cur_dir_ff];
         rsp_ff.last          <= cur_dir_ff;
         if (count_zero_ff) begin
            rsp_ff.value_first  <= '0;
            rsp_ff.value_second <= '0;
            rsp_ff.value_third  <= '0;
            rsp_ff.max_value    <= '0;
         end else begin
            rsp_ff.value_first  <= midpoint(found_ff[0], hit_idx_ff[0]);
            rsp_ff.value_second <= midpoint(found_ff[1], hit_idx_ff[1]);
            rsp_ff.value_third  <= midpoint(found_ff[2], hit_idx_ff[2]);
            rsp_ff.max_value    <= max_seen_ff ? (33'(1) << max_shift) : 33'd0;
         end
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   assign sts.totals_zero = (op_ff[0] == '0) && (op_ff[1] == '0);
   assign sts.scan_last   = (idx_ff == SW'(BUCKETS - 1));
   assign sts.pipe_busy   = p1_vld_ff || p2_vld_ff || p3_vld_ff;
   assign sts.rsp_free    = !rsp_valid_ff || !rsp_stall;

   a_rsp_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      cmd.rsp_load |-> sts.rsp_free)
      else $error("result register loaded while a result is still held");

   a_add_write_after_capture: assert property (@(posedge clock) disable iff (reset)
      cmd.add_write |-> $past(cmd.add_capture))
      else $error("bucket write without a captured add");

   a_clear_after_last: assert property (@(posedge clock) disable iff (reset)
      (cmd.rsp_load && cur_dir_ff) |=> sts.totals_zero)
      else $error("totals not cleared after the final result");

   a_load_pipe_empty: assert property (@(posedge clock) disable iff (reset)
      cmd.load |-> !sts.pipe_busy)
      else $error("scan context reloaded while the pipeline still runs");

endmodule

`default_nettype wire

### sv/lhpe_ctrl.sv
// ============================================================================
// lhpe_ctrl
// Sequencer for add and report beats of the histogram percentile engine.
// ============================================================================
`default_nettype none

module lhpe_ctrl (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_valid,
   input  wire logic                  req_command,
   output logic                       req_stall,
   input  wire lhpe_pkg::dp_sts_type  sts,
   output lhpe_pkg::dp_cmd_type       cmd
);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_ADD_WR,
      ST_LOAD,
      ST_SCAN,
      ST_DRAIN,
      ST_EMIT
   } state_type;

   state_type state_ff, state_in;
   logic      dir_ff, dir_in;
   logic      req_accept;

   assign req_stall  = (state_ff != ST_IDLE);
   assign req_accept = req_valid && !req_stall;

   always_comb begin
      state_in = state_ff;
      dir_in   = dir_ff;
      cmd      = '0;
      cmd.load_dir = dir_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               if (req_command == lhpe_pkg::CMD_ADD) begin
                  cmd.add_capture = 1'b1;
                  state_in        = ST_ADD_WR;
               end else if (sts.totals_zero) begin
                  // Nothing to report: clear and stay idle.
                  cmd.clear_all = 1'b1;
               end else begin
                  dir_in   = 1'b0;
                  state_in = ST_LOAD;
               end
            end
         end
         ST_ADD_WR: begin
            cmd.add_write = 1'b1;
            state_in      = ST_IDLE;
         end
         ST_LOAD: begin
            cmd.load = 1'b1;
            state_in = ST_SCAN;
         end
         ST_SCAN: begin
            cmd.scan_step = 1'b1;
            if (sts.scan_last) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            if (!sts.pipe_busy) begin
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (sts.rsp_free) begin
               cmd.rsp_load = 1'b1;
               if (dir_ff) begin
                  cmd.clear_all = 1'b1;
                  state_in      = ST_IDLE;
               end else begin
                  dir_in   = 1'b1;
                  state_in = ST_LOAD;
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         dir_ff   <= 1'b0;
      end else begin
         state_ff <= state_in;
         dir_ff   <= dir_in;
      end
   end

   a_scan_follows_load: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SCAN && $past(state_ff) != ST_SCAN) |-> $past(state_ff == ST_LOAD))
      else $error("scan started without loading the report context");

   a_emit_write_after_read: assert property (@(posedge clock) disable iff (reset)
      (cmd.rsp_load && dir_ff) |-> (state_ff == ST_EMIT))
      else $error("write result loaded outside the emit step");

   a_stall_while_busy: assert property (@(posedge clock) disable iff (reset)
      (cmd.scan_step || cmd.add_write) |-> req_stall)
      else $error("request taken while the datapath is busy");

endmodule

`default_nettype wire

### sv/log2_histogram_percentile_engine_top.sv
// Add beat: captured in the accepting cycle, then a read-modify-write on the bucket memory,
//    so the block takes no new request until the bucket write is done.
// Report beat: per direction a load step, a scan step per bucket (one memory read each),
//    then a drain of the scan pipeline and a result step.
// Report with both counts zero: finished in the accepting cycle and gives no result.
// Reset is synchronous: bucket valid bits and totals clear at once, percents go to 50/95/99.
// ============================================================================
// log2_histogram_percentile_engine_top
// Read and write power-of-two latency histograms with percentile reporting.
// ============================================================================
`default_nettype none

module log2_histogram_percentile_engine_top #(
   parameter int BUCKETS = 32
) (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               req_valid,
   output logic                                    req_stall,
   input  wire lhpe_pkg::req_type                  req_data,
   output logic                                    rsp_valid,
   input  wire logic                               rsp_stall,
   output lhpe_pkg::rsp_type                       rsp_data,
   input  wire logic                               csr_write_en,
   input  wire logic [lhpe_pkg::CSR_IDX_W-1:0]     csr_index,
   input  wire logic [lhpe_pkg::PCT_W-1:0]         csr_wdata
);

   // The controller owns the sequence of a beat and its state; the datapath owns every other
   // piece of storage. They talk only through the command and status structs below.
   lhpe_pkg::dp_cmd_type cmd;
   lhpe_pkg::dp_sts_type sts;

   // The controller takes a request beat only when idle. An add beat becomes a
   // capture step (memory read plus the 64-bit total updates) and a write step.
   // A report beat walks the read direction, then the write direction: each walk
   // loads the percentile products, streams the buckets through the scan pipeline,
   // waits for it to drain and hands the result to the output register. A result
   // that is still held by rsp_stall keeps the walk in its result cycle.
   lhpe_ctrl u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_command (req_data.command),
      .req_stall   (req_stall),
      .sts         (sts),
      .cmd         (cmd)
   );

   // The datapath compares 100 * (running sum + 1) against count * percent, which
   // reproduces the exact floor(count * percent / 100) target without a divider.
   // A percent above 100 is used as given, so its target may lie above the count;
   // a level whose target no running sum reaches reports 2^(BUCKETS-1).
   // The result register decouples the two sides: a new request beat is taken while
   // the final result of a report still waits for rsp_stall to drop.
   lhpe_datapath #(
      .BUCKETS (BUCKETS)
   ) u_datapath (
      .clock        (clock),
      .reset        (reset),
      .req_data     (req_data),
      .rsp_valid    (rsp_valid),
      .rsp_stall    (rsp_stall),
      .rsp_data     (rsp_data),
      .csr_write_en (csr_write_en),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata),
      .cmd          (cmd),
      .sts          (sts)
   );

endmodule

`default_nettype wire

### bench/testbench.sv
// ============================================================================
// testbench
// Self-checking bench for the log2 histogram percentile engine.
// Adds and reports are driven through the request channel, and every
// accepted beat is folded into a bit-accurate tracker of both histograms.
// Result beats are compared field by field against the predicted reports.
// The run goes through four idling phases and several percent settings.
// ============================================================================

module testbench;

   localparam int BUCKETS = 32;

   // Direction codes carried by the direction fields.
   localparam logic DIR_READ  = 1'b0;
   localparam logic DIR_WRITE = 1'b1;

   // A report scans every bucket once per direction and drains a short
   // pipeline, so this many cycles covers any work still in flight.
   localparam int SETTLE_CYCLES = 2 * (BUCKETS + 5) + 20;

   // Length of the long receiver hold-off that fills the block up.
   localparam int HOLD_CYCLES = 400;

   // Cycles without any accepted beat or register write before giving up.
   localparam int QUIET_LIMIT = 5000;

   // Random beats per idling phase; with the directed beats this gives
   // roughly 450 request beats in all.
   localparam int PHASE_BEATS = 107;

   // -------------------------------------------------------------------------
   // Histogram tracker: keeps its own copy of the buckets, totals and percent
   // levels, and holds the reports that the block still owes.
   // -------------------------------------------------------------------------
   class histogram_tracker;
      logic [31:0]                bucket_sum [2][BUCKETS];
      logic [63:0]                op_total [2];
      logic [63:0]                byte_total [2];
      logic [lhpe_pkg::PCT_W-1:0] pct_level [lhpe_pkg::NUM_PCT];
      lhpe_pkg::rsp_type          owed_reports [$];
      int                         mismatches;

      function new();
         clear_totals();
         pct_level[0] = lhpe_pkg::PCT_FIRST_RESET;
         pct_level[1] = lhpe_pkg::PCT_SECOND_RESET;
         pct_level[2] = lhpe_pkg::PCT_THIRD_RESET;
         mismatches   = 0;
      endfunction

      function void clear_totals();
         foreach (bucket_sum[d, i]) bucket_sum[d][i] = '0;
         foreach (op_total[d]) begin
            op_total[d]   = '0;
            byte_total[d] = '0;
         end
      endfunction

      function void set_level(logic [lhpe_pkg::CSR_IDX_W-1:0] index,
                              logic [lhpe_pkg::PCT_W-1:0] level);
         case (index)
            lhpe_pkg::CSR_PCT_FIRST:  pct_level[0] = level;
            lhpe_pkg::CSR_PCT_SECOND: pct_level[1] = level;
            lhpe_pkg::CSR_PCT_THIRD:  pct_level[2] = level;
            default: ;
         endcase
      endfunction

      // The target is floor(count * p / 100) taken over the full 71-bit
      // product; a target that needs more than 64 bits saturates to all ones
      // and can then never be reached by the bucket sum.
      function logic [31:0] midpoint_at(int dir, logic [63:0] count,
                                        logic [lhpe_pkg::PCT_W-1:0] p);
         logic [70:0] scaled;
         logic [70:0] quotient;
         logic [63:0] target;
         logic [63:0] running;
         scaled   = {7'd0, count} * {64'd0, p};
         quotient = scaled / 71'd100;
         target   = (quotient[70:64] != '0) ? '1 : quotient[63:0];
         running  = '0;
         for (int i = 0; i < BUCKETS; i++) begin
            running += {32'd0, bucket_sum[dir][i]};
            if (running >= target) begin
               return (i == 0) ? 32'd1 : (32'd3 << (i - 1));
            end
         end
         return 32'd1 << (BUCKETS - 1);
      endfunction

      function void record_request(lhpe_pkg::req_type beat);
         lhpe_pkg::rsp_type r;
         if (beat.command == lhpe_pkg::CMD_ADD) begin
            bucket_sum[beat.direction][beat.slot] += beat.slot_add;
            op_total[beat.direction]   += beat.count_add;
            byte_total[beat.direction] += beat.bytes_add;
            return;
         end
         // A report with both counts at zero owes nothing, but still clears.
         if (op_total[0] != '0 || op_total[1] != '0) begin
            for (int d = 0; d < 2; d++) begin
               r               = '0;
               r.out_direction = d[0];
               r.op_count      = op_total[d];
               r.op_bytes      = byte_total[d];
               if (op_total[d] != '0) begin
                  r.value_first  = midpoint_at(d, op_total[d], pct_level[0]);
                  r.value_second = midpoint_at(d, op_total[d], pct_level[1]);
                  r.value_third  = midpoint_at(d, op_total[d], pct_level[2]);
                  // The highest nonempty bucket wins; an empty histogram
                  // leaves the maximum at zero.
                  for (int i = 0; i < BUCKETS; i++) begin
                     if (bucket_sum[d][i] != '0) r.max_value = 33'd1 << (i + 1);
                  end
               end
               r.last = (d[0] == DIR_WRITE);
               owed_reports.push_back(r);
            end
         end
         clear_totals();
      endfunction

      function void check_report(lhpe_pkg::rsp_type got);
         lhpe_pkg::rsp_type want;
         string             wrong;
         if (owed_reports.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) begin
               $display("unexpected result beat: dir=%0d count=%0h bytes=%0h",
                        got.out_direction, got.op_count, got.op_bytes);
            end
            return;
         end
         want  = owed_reports.pop_front();
         wrong = "";
         if (got.out_direction !== want.out_direction) wrong = {wrong, " out_direction"};
         if (got.op_count      !== want.op_count)      wrong = {wrong, " op_count"};
         if (got.op_bytes      !== want.op_bytes)      wrong = {wrong, " op_bytes"};
         if (got.value_first   !== want.value_first)   wrong = {wrong, " value_first"};
         if (got.value_second  !== want.value_second)  wrong = {wrong, " value_second"};
         if (got.value_third   !== want.value_third)   wrong = {wrong, " value_third"};
         if (got.max_value     !== want.max_value)     wrong = {wrong, " max_value"};
         if (got.last          !== want.last)          wrong = {wrong, " last"};
         if (wrong != "") begin
            mismatches++;
            if (mismatches <= 10) begin
               $display("result mismatch in%s", wrong);
               $display("  expected dir=%0d count=%0h bytes=%0h p=%0h/%0h/%0h max=%0h last=%0d",
                        want.out_direction, want.op_count, want.op_bytes, want.value_first,
                        want.value_second, want.value_third, want.max_value, want.last);
               $display("  actual   dir=%0d count=%0h bytes=%0h p=%0h/%0h/%0h max=%0h last=%0d",
                        got.out_direction, got.op_count, got.op_bytes, got.value_first,
                        got.value_second, got.value_third, got.max_value, got.last);
            end
         end
      endfunction

      function int owed();
         return owed_reports.size();
      endfunction
   endclass

   // -------------------------------------------------------------------------
   // Signals. Every input of the block starts at a known value.
   // -------------------------------------------------------------------------
   logic                           clock        = 1'b0;
   logic                           reset        = 1'b1;
   logic                           req_valid    = 1'b0;
   logic                           req_stall;
   lhpe_pkg::req_type              req_data     = '0;
   logic                           rsp_valid;
   logic                           rsp_stall    = 1'b0;
   lhpe_pkg::rsp_type              rsp_data;
   logic                           csr_write_en = 1'b0;
   logic [lhpe_pkg::CSR_IDX_W-1:0] csr_index    = lhpe_pkg::CSR_PCT_FIRST;
   logic [lhpe_pkg::PCT_W-1:0]     csr_wdata    = '0;

   histogram_tracker tracker;

   // Idling percentages of the current phase, set by the main sequence.
   int send_idle_pct  = 0;
   int recv_stall_pct = 0;

   // The main sequence bumps hold_requests; the stall process notices the
   // change and starts counting its own hold-off.
   int hold_requests = 0;
   int hold_seen     = 0;
   int hold_left     = 0;

   int beats_sent  = 0;
   int quiet_count = 0;

   log2_histogram_percentile_engine_top #(
      .BUCKETS (BUCKETS)
   ) u_top (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_stall    (req_stall),
      .req_data     (req_data),
      .rsp_valid    (rsp_valid),
      .rsp_stall    (rsp_stall),
      .rsp_data     (rsp_data),
      .csr_write_en (csr_write_en),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // Receiver side: random stall at the phase's rate, or a solid hold-off
   // when one has been asked for.
   always @(posedge clock) begin
      if (hold_seen != hold_requests) begin
         hold_seen = hold_requests;
         hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= ($urandom_range(99) < recv_stall_pct);
      end
   end

   // Every result beat that the receiver takes is checked right away.
   // Outputs are sampled before the edge's updates land, so the values
   // seen here are the ones the block presented during the cycle.
   always @(posedge clock) begin
      if (!reset && rsp_valid === 1'b1 && rsp_stall === 1'b0) begin
         tracker.check_report(rsp_data);
      end
   end

   // Watchdog: a long stretch with no accepted beat and no register write
   // means the block has hung.
   always @(posedge clock) begin
      if (reset || (req_valid && req_stall === 1'b0) ||
          (rsp_valid === 1'b1 && !rsp_stall) || csr_write_en) begin
         quiet_count <= 0;
      end else if (quiet_count >= QUIET_LIMIT) begin
         $display("FAILURE");
         $finish;
      end else begin
         quiet_count <= quiet_count + 1;
      end
   end

   // -------------------------------------------------------------------------
   // Stimulus helpers.
   // -------------------------------------------------------------------------

   // Offers one beat, idling first at the phase's rate. The beat is held
   // steady until the block takes it, and only then noted in the tracker.
   // Valid is left high on return, so back-to-back beats never lower it.
   task automatic send_beat(lhpe_pkg::req_type beat);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= beat;
      @(posedge clock);
      while (req_stall !== 1'b0) @(posedge clock);
      tracker.record_request(beat);
      beats_sent++;
   endtask

   task automatic send_add(logic dir, logic [4:0] slot, logic [31:0] amount,
                           logic [63:0] count, logic [63:0] bytes);
      lhpe_pkg::req_type beat;
      beat.command   = lhpe_pkg::CMD_ADD;
      beat.direction = dir;
      beat.slot      = slot;
      beat.slot_add  = amount;
      beat.count_add = count;
      beat.bytes_add = bytes;
      send_beat(beat);
   endtask

   // The block ignores every field of a report but the command; the other
   // fields carry random bits all the same.
   task automatic send_report();
      lhpe_pkg::req_type beat;
      beat.command   = lhpe_pkg::CMD_REPORT;
      beat.direction = 1'($urandom);
      beat.slot      = 5'($urandom);
      beat.slot_add  = $urandom;
      beat.count_add = {$urandom, $urandom};
      beat.bytes_add = {$urandom, $urandom};
      send_beat(beat);
   endtask

   // Most adds look like real traffic: a handful of operations landing in
   // one bucket, counted with up to two extra. Others push the wide fields to
   // extremes so every bit moves and the totals wrap, or leave count or amount 0.
   task automatic send_random_add();
      logic [31:0] amount;
      logic [63:0] count;
      logic [63:0] bytes;
      bytes = {$urandom, $urandom};
      case ($urandom_range(9))
         0: begin
            amount = $urandom;
            count  = {$urandom, $urandom};
         end
         1: begin
            amount = 32'hFFFF_FFFF;
            count  = '1;
            bytes  = '1;
         end
         2: begin
            amount = $urandom_range(0, 3);
            count  = 64'd0;
         end
         3: begin
            amount = 32'd0;
            count  = 64'($urandom_range(1, 30));
         end
         default: begin
            amount = $urandom_range(1, 40);
            count  = {32'd0, amount} + 64'($urandom_range(0, 2));
            bytes  = {32'd0, $urandom} * {32'd0, amount};
         end
      endcase
      send_add(1'($urandom_range(1)), 5'($urandom_range(31)), amount, count, bytes);
   endtask

   // Waits until every owed report has come back, then lets any add or
   // empty report that is still in the pipeline run out.
   task automatic drain_block();
      req_valid <= 1'b0;
      while (tracker.owed() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_level(logic [lhpe_pkg::CSR_IDX_W-1:0] index,
                              logic [lhpe_pkg::PCT_W-1:0] level);
      csr_write_en <= 1'b1;
      csr_index    <= index;
      csr_wdata    <= level;
      @(posedge clock);
      tracker.set_level(index, level);
   endtask

   // -------------------------------------------------------------------------
   // Main sequence.
   // -------------------------------------------------------------------------
   initial begin
      int phase_goal;
      tracker = new();

      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      for (int phase = 0; phase < 4; phase++) begin
         // Phase 0 runs flat out, then the sender idles, then the receiver
         // stalls, and last both do so at a lighter rate.
         case (phase)
            0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            1: begin send_idle_pct = 75; recv_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  recv_stall_pct = 75; end
            default: begin send_idle_pct = 28; recv_stall_pct = 28; end
         endcase

         if (phase == 0) begin
            // An empty report owes nothing.
            send_report();
            // One operation in the lowest bucket; the write side reports
            // a zero count with its bytes and values all zero.
            send_add(DIR_READ, 5'd0, 32'd1, 64'd1, 64'd0);
            send_report();
            // The write bucket and both write totals wrap back to zero, and
            // the read side has buckets but no count, so nothing is owed.
            send_add(DIR_WRITE, 5'd31, 32'hFFFF_FFFF, '1, '1);
            send_add(DIR_WRITE, 5'd31, 32'd1, 64'd1, 64'd1);
            send_add(DIR_READ, 5'd7, 32'd5, 64'd0, 64'd123);
            send_add(DIR_WRITE, 5'd2, 32'd0, 64'd0, 64'd0);
            send_report();
            // A count with an empty histogram: the maximum is zero and the
            // targets are never reached. The write side has a bucket and
            // no count.
            send_add(DIR_READ, 5'd4, 32'd0, 64'd10, 64'd4096);
            send_add(DIR_WRITE, 5'd3, 32'd7, 64'd0, 64'd99);
            send_report();
            // Percentiles spread across buckets, a target far above all the
            // buckets, and bucket sums that pass 32 bits without wrapping.
            send_add(DIR_READ, 5'd0, 32'd3, 64'd100, 64'd800);
            send_add(DIR_READ, 5'd10, 32'd90, 64'd0, 64'd0);
            send_add(DIR_READ, 5'd31, 32'd7, 64'd0, 64'd0);
            send_add(DIR_WRITE, 5'd20, 32'hFFFF_FFFF, 64'hFFFF_FFFF_0000_0000, 64'd1);
            send_add(DIR_WRITE, 5'd21, 32'hFFFF_FFFF, 64'd0, 64'd0);
            send_report();
            // The top bucket alone: every target is zero, so each level gives
            // the lowest midpoint, and the maximum is 2^32.
            send_add(DIR_READ, 5'd31, 32'd1, 64'd1, 64'd1);
            send_report();

            // Hold the receiver off for a long stretch while the sender keeps
            // going, so reports pile up and the block stalls its input.
            hold_requests++;
         end else begin
            // Percent levels may change only while the block is idle.
            drain_block();
            case (phase)
               1: begin
                  write_level(lhpe_pkg::CSR_PCT_FIRST, 7'd0);
                  write_level(lhpe_pkg::CSR_PCT_SECOND, 7'd100);
                  write_level(lhpe_pkg::CSR_PCT_THIRD, 7'd127);
               end
               2: begin
                  write_level(lhpe_pkg::CSR_PCT_FIRST, 7'd127);
                  write_level(lhpe_pkg::CSR_PCT_SECOND, 7'd1);
                  write_level(lhpe_pkg::CSR_PCT_THIRD, 7'd100);
               end
               default: begin
                  write_level(lhpe_pkg::CSR_PCT_FIRST, 7'($urandom_range(127)));
                  write_level(lhpe_pkg::CSR_PCT_SECOND, 7'($urandom_range(127)));
                  write_level(lhpe_pkg::CSR_PCT_THIRD, 7'($urandom_range(127)));
               end
            endcase
            csr_write_en <= 1'b0;
            // A full-scale count: above 100 percent the target no longer
            // fits in 64 bits and saturates.
            send_add(1'($urandom_range(1)), 5'($urandom_range(31)), $urandom, '1,
                     {$urandom, $urandom});
            send_report();
         end

         // Well-formed traffic: a few adds closed by a report. A run with no
         // adds gives a bare report, and now and then a stray extra report
         // lands on freshly cleared state.
         phase_goal = beats_sent + PHASE_BEATS;
         while (beats_sent < phase_goal) begin
            repeat ($urandom_range(0, 8)) send_random_add();
            send_report();
            if ($urandom_range(9) == 0) send_report();
         end
      end

      drain_block();

      if (tracker.mismatches == 0 && tracker.owed() == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule

### log2_histogram_percentile_engine_top.f
sv/lhpe_pkg.sv
sv/lhpe_datapath.sv
sv/lhpe_ctrl.sv
sv/log2_histogram_percentile_engine_top.sv
bench/testbench.sv
